@@ hdl/w2p_pkg.sv @@
// shared types and constants for the world to pixel projection
package w2p_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned RegW    = 20;
  localparam int unsigned PixW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned QBits   = 25;
  localparam int unsigned DivLat  = QBits + 3;

  localparam logic [CfgIdxW-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 3'd3;

  localparam logic signed [PixW-1:0] PIX_MAX = 24'sh7FFFFF;
  localparam logic signed [PixW-1:0] PIX_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [QuatW-1:0]  quat_w;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [CoordW-1:0] trans_x;
    logic signed [CoordW-1:0] trans_y;
    logic signed [CoordW-1:0] trans_z;
  } req_t;

  typedef struct packed {
    logic signed [PixW-1:0]   pixel_u;
    logic signed [PixW-1:0]   pixel_v;
    logic signed [CoordW-1:0] cam_depth;
    logic                     in_front;
  } res_t;

endpackage

@@ hdl/w2p_div.sv @@
// pipelined focal scaling, rounded divide by depth and center offset
module w2p_div (
  input  logic                                clk_i,
  input  logic [w2p_pkg::RegW-1:0]            focal_i,
  input  logic [w2p_pkg::RegW-1:0]            center_i,
  input  logic signed [w2p_pkg::CoordW-1:0]   coord_i,
  input  logic signed [w2p_pkg::CoordW-1:0]   depth_i,
  output logic signed [w2p_pkg::PixW-1:0]     pix_o
);
  import w2p_pkg::*;

  logic signed [52:0]       n_q;
  logic signed [CoordW-1:0] z_q;

  logic [33:0]       rem_q [QBits+1];
  logic [QBits-1:0]  quo_q [QBits+1];
  logic [QBits-1:0]  nlo_q [QBits+1];
  logic [32:0]       dvs_q [QBits+1];
  logic              neg_q [QBits+1];
  logic              ovf_q [QBits+1];

  logic [52:0] mag;
  logic [53:0] num;
  logic [32:0] dvs;
  logic [57:0] lim;
  logic signed [PixW-1:0] pix_d;
  logic signed [26:0]     qv;
  logic signed [26:0]     sum;

  always_ff @(posedge clk_i) begin
    n_q <= $signed({1'b0, focal_i}) * coord_i;
    z_q <= depth_i;
  end

  // rounded quotient of |n| by z: floor((2|n| + z) / 2z)
  always_comb begin
    mag = n_q[52] ? 53'(-n_q) : 53'(n_q);
    num = 54'({mag[51:0], 1'b0}) + 54'(unsigned'(z_q));
    dvs = {z_q, 1'b0};
    lim = {dvs, {QBits{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= 34'(num[53:QBits]);
    nlo_q[0] <= num[QBits-1:0];
    quo_q[0] <= '0;
    dvs_q[0] <= dvs;
    neg_q[0] <= n_q[52];
    ovf_q[0] <= 58'(num) >= lim;
  end

  for (genvar k = 0; k < QBits; k++) begin : g_stage
    logic [33:0] cand;
    logic        ge;
    always_comb begin
      cand = {rem_q[k][32:0], nlo_q[k][QBits-1]};
      ge   = cand >= {1'b0, dvs_q[k]};
    end
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? cand - {1'b0, dvs_q[k]} : cand;
      quo_q[k+1] <= {quo_q[k][QBits-2:0], ge};
      nlo_q[k+1] <= {nlo_q[k][QBits-2:0], 1'b0};
      dvs_q[k+1] <= dvs_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  always_comb begin
    qv  = neg_q[QBits] ? -27'({2'b00, quo_q[QBits]}) : 27'({2'b00, quo_q[QBits]});
    sum = qv + 27'(center_i);
    if (ovf_q[QBits]) begin
      pix_d = neg_q[QBits] ? PIX_MIN : PIX_MAX;
    end else if (sum > 27'(PIX_MAX)) begin
      pix_d = PIX_MAX;
    end else if (sum < 27'(PIX_MIN)) begin
      pix_d = PIX_MIN;
    end else begin
      pix_d = sum[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pix_o <= pix_d;
  end

endmodule

@@ hdl/world_to_pixel_projection.sv @@
// top level: rigid transform of a world point and pinhole projection to pixels
// the result strobe follows the accepting edge through 32 register stages
// throughput: one request per cycle, every stage of transform and divide is registered
// busy stays low: the pipeline never stalls since the receiver cannot hold results
// reset clears the valid bits and the intrinsic registers to zero
module world_to_pixel_projection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  w2p_pkg::req_t                  req_i,
  output logic                           res_valid_o,
  output w2p_pkg::res_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [w2p_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [w2p_pkg::CfgDatW-1:0]    cfg_data_i
);
  import w2p_pkg::*;

  localparam logic signed [34:0] QOne = 35'sd268435456;
  localparam logic signed [34:0] RLim = 35'sd1073741824;

  function automatic logic signed [31:0] sat_r(input logic signed [34:0] v);
    logic signed [34:0] c;
    c = (v > RLim) ? RLim : ((v < -RLim) ? -RLim : v);
    return c[31:0];
  endfunction

  logic [RegW-1:0] fx_q, fy_q, cx_q, cy_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= '0;
      fy_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FOCAL_X:  fx_q <= cfg_data_i[RegW-1:0];
        REG_FOCAL_Y:  fy_q <= cfg_data_i[RegW-1:0];
        REG_CENTER_X: cx_q <= cfg_data_i[RegW-1:0];
        REG_CENTER_Y: cy_q <= cfg_data_i[RegW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of the transform stages
  logic [3:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start & ~busy};
    end
  end

  // stage 1: quaternion products
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [CoordW-1:0] p1_q [3];
  logic signed [CoordW-1:0] t1_q [3];

  always_ff @(posedge clk_i) begin
    xx_q <= req_i.quat_x * req_i.quat_x;
    yy_q <= req_i.quat_y * req_i.quat_y;
    zz_q <= req_i.quat_z * req_i.quat_z;
    xy_q <= req_i.quat_x * req_i.quat_y;
    xz_q <= req_i.quat_x * req_i.quat_z;
    yz_q <= req_i.quat_y * req_i.quat_z;
    wx_q <= req_i.quat_w * req_i.quat_x;
    wy_q <= req_i.quat_w * req_i.quat_y;
    wz_q <= req_i.quat_w * req_i.quat_z;
    p1_q[0] <= req_i.point_x;
    p1_q[1] <= req_i.point_y;
    p1_q[2] <= req_i.point_z;
    t1_q[0] <= req_i.trans_x;
    t1_q[1] <= req_i.trans_y;
    t1_q[2] <= req_i.trans_z;
  end

  // stage 2: rotation matrix in q.28, saturated
  logic signed [31:0]       r_q [3][3];
  logic signed [CoordW-1:0] p2_q [3];
  logic signed [CoordW-1:0] t2_q [3];

  always_ff @(posedge clk_i) begin
    r_q[0][0] <= sat_r(QOne - ((35'(yy_q) + 35'(zz_q)) <<< 1));
    r_q[0][1] <= sat_r((35'(xy_q) - 35'(wz_q)) <<< 1);
    r_q[0][2] <= sat_r((35'(xz_q) + 35'(wy_q)) <<< 1);
    r_q[1][0] <= sat_r((35'(xy_q) + 35'(wz_q)) <<< 1);
    r_q[1][1] <= sat_r(QOne - ((35'(xx_q) + 35'(zz_q)) <<< 1));
    r_q[1][2] <= sat_r((35'(yz_q) - 35'(wx_q)) <<< 1);
    r_q[2][0] <= sat_r((35'(xz_q) - 35'(wy_q)) <<< 1);
    r_q[2][1] <= sat_r((35'(yz_q) + 35'(wx_q)) <<< 1);
    r_q[2][2] <= sat_r(QOne - ((35'(xx_q) + 35'(yy_q)) <<< 1));
    p2_q <= p1_q;
    t2_q <= t1_q;
  end

  // stage 3: matrix times point products
  logic signed [63:0]       m_q [3][3];
  logic signed [CoordW-1:0] t3_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_q[i][j] <= r_q[i][j] * p2_q[j];
      end
    end
    t3_q <= t2_q;
  end

  // stage 4: round to q.16, translate, saturate
  logic signed [CoordW-1:0] cam_q [3];
  logic signed [CoordW-1:0] cam_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] acc;
      logic signed [36:0] s;
      acc = m_q[i][0] + m_q[i][1] + m_q[i][2] + 64'sd134217728;
      s   = 37'($signed(acc[63:28])) + 37'(t3_q[i]);
      if (s > 37'sd2147483647) begin
        cam_d[i] = 32'sh7FFFFFFF;
      end else if (s < -37'sd2147483648) begin
        cam_d[i] = 32'sh80000000;
      end else begin
        cam_d[i] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cam_q <= cam_d;
  end

  // projection of both axes
  logic signed [PixW-1:0] u_pix, v_pix;

  w2p_div u_div (
    .clk_i    (clk_i),
    .focal_i  (fx_q),
    .center_i (cx_q),
    .coord_i  (cam_q[0]),
    .depth_i  (cam_q[2]),
    .pix_o    (u_pix)
  );

  w2p_div v_div (
    .clk_i    (clk_i),
    .focal_i  (fy_q),
    .center_i (cy_q),
    .coord_i  (cam_q[1]),
    .depth_i  (cam_q[2]),
    .pix_o    (v_pix)
  );

  // depth and valid travel beside the divide pipeline
  logic                     dv_q [DivLat];
  logic signed [CoordW-1:0] dz_q [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLat; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else begin
      dv_q[0] <= vld_q[3];
      for (int k = 1; k < DivLat; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dz_q[0] <= cam_q[2];
    for (int k = 1; k < DivLat; k++) begin
      dz_q[k] <= dz_q[k-1];
    end
  end

  logic front;
  assign front = dz_q[DivLat-1] > 32'sd0;

  assign res_valid_o       = dv_q[DivLat-1];
  assign res_o.pixel_u     = front ? u_pix : '0;
  assign res_o.pixel_v     = front ? v_pix : '0;
  assign res_o.cam_depth   = dz_q[DivLat-1];
  assign res_o.in_front    = front;

endmodule
